[rtl/core/btx_pkg.sv]
package btx_pkg;

    localparam int NUM_REGS = 7;

    localparam logic [2:0] KIND_REG   = 3'd0;
    localparam logic [2:0] KIND_WRITE = 3'd1;
    localparam logic [2:0] KIND_READ  = 3'd2;
    localparam logic [2:0] KIND_BAD   = 3'd3;
    localparam logic [2:0] KIND_STRAY = 3'd4;

    localparam logic [2:0] REG_B  = 3'd0;
    localparam logic [2:0] REG_C  = 3'd1;
    localparam logic [2:0] REG_D  = 3'd2;
    localparam logic [2:0] REG_E  = 3'd3;
    localparam logic [2:0] REG_H  = 3'd4;
    localparam logic [2:0] REG_L  = 3'd5;
    localparam logic [2:0] NO_REG = 3'd6;
    localparam logic [2:0] REG_A  = 3'd7;

    localparam logic [3:0] CYC_MOV     = 4'd5;
    localparam logic [3:0] CYC_SHORT   = 4'd7;
    localparam logic [3:0] CYC_MVI_MEM = 4'd10;
    localparam logic [3:0] CYC_DIRECT  = 4'd13;

    localparam logic [7:0] OP_STAX_B   = 8'h02;
    localparam logic [7:0] OP_STAX_D   = 8'h12;
    localparam logic [7:0] OP_LDAX_B   = 8'h0A;
    localparam logic [7:0] OP_LDAX_D   = 8'h1A;
    localparam logic [7:0] OP_STA      = 8'h32;
    localparam logic [7:0] OP_LDA      = 8'h3A;
    localparam logic [7:0] OP_MOV_MM   = 8'h76;
    localparam logic [7:0] OP_MOV_LO   = 8'h40;
    localparam logic [7:0] OP_MOV_HI   = 8'h7F;
    localparam logic [7:0] OP_MVI_MASK = 8'hC7;
    localparam logic [7:0] OP_MVI_PAT  = 8'h06;

    typedef logic [NUM_REGS-1:0][7:0] regs_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] mem_addr;
        logic [7:0]  write_data;
        logic [2:0]  dest_index;
        logic [7:0]  dest_value;
        logic [3:0]  cycle_count;
        logic [1:0]  pc_inc;
        logic        reg_we;
        logic [2:0]  reg_code;
        logic [7:0]  reg_wdata;
        logic        pend_set;
        logic        pend_clear;
        logic [2:0]  pend_dest;
        logic [3:0]  pend_cycles;
    } exec_t;

    // storage slot of a register code; A (and the unused code) live in the last slot
    function automatic logic [2:0] slot_of(input logic [2:0] code);
        return (code > REG_L) ? 3'd6 : code;
    endfunction

endpackage

[rtl/core/byte_transfer_execute_unit.sv]
// Executes the 8-bit transfer group (MOV, MVI, STAX, LDAX, STA, LDA) against
// its own B,C,D,E,H,L,A registers and 16-bit PC. One item (an instruction or
// the read data that completes a pending load) is taken every clock unless the
// pipe is held; its result passes through the input register and then the result
// register, with decode, register-file read and PC add between them. A full
// result register with m_ready low holds the pipe; s_ready stays high as long
// as the result register is empty or being taken.
module byte_transfer_execute_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_opcode,
    input  logic [15:0] s_operand_word,
    input  logic [7:0]  s_read_data,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [15:0] m_mem_addr,
    output logic [7:0]  m_write_data,
    output logic [2:0]  m_dest_index,
    output logic [7:0]  m_dest_value,
    output logic [3:0]  m_cycle_count,
    output logic [15:0] m_next_pc
);

    logic        in_valid_reg;
    logic        action_reg;
    logic [7:0]  opcode_reg;
    logic [15:0] operand_reg;
    logic [7:0]  rdata_reg;

    logic [15:0] pc_reg;
    logic [15:0] pc_next;
    logic        load_pending_reg;
    logic [2:0]  pending_dest_reg;
    logic [3:0]  pending_cycles_reg;

    logic        m_valid_reg;
    logic [2:0]  m_kind_reg;
    logic [15:0] m_mem_addr_reg;
    logic [7:0]  m_write_data_reg;
    logic [2:0]  m_dest_index_reg;
    logic [7:0]  m_dest_value_reg;
    logic [3:0]  m_cycle_count_reg;
    logic [15:0] m_next_pc_reg;

    logic           advance;
    logic           fire;
    btx_pkg::regs_t regs;
    btx_pkg::exec_t ex;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign fire    = in_valid_reg && advance;
    assign pc_next = pc_reg + {14'd0, ex.pc_inc};

    btx_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (fire && ex.reg_we),
        .code    (ex.reg_code),
        .wdata   (ex.reg_wdata),
        .regs    (regs)
    );

    btx_exec u_exec (
        .action         (action_reg),
        .opcode         (opcode_reg),
        .operand_word   (operand_reg),
        .read_data      (rdata_reg),
        .regs           (regs),
        .load_pending   (load_pending_reg),
        .pending_dest   (pending_dest_reg),
        .pending_cycles (pending_cycles_reg),
        .ex             (ex)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg  <= s_action;
            opcode_reg  <= s_opcode;
            operand_reg <= s_operand_word;
            rdata_reg   <= s_read_data;
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg             <= '0;
            load_pending_reg   <= 1'b0;
            pending_dest_reg   <= '0;
            pending_cycles_reg <= '0;
        end else if (fire) begin
            pc_reg <= pc_next;
            if (ex.pend_set) begin
                load_pending_reg   <= 1'b1;
                pending_dest_reg   <= ex.pend_dest;
                pending_cycles_reg <= ex.pend_cycles;
            end else if (ex.pend_clear) begin
                load_pending_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_kind_reg        <= ex.kind;
            m_mem_addr_reg    <= ex.mem_addr;
            m_write_data_reg  <= ex.write_data;
            m_dest_index_reg  <= ex.dest_index;
            m_dest_value_reg  <= ex.dest_value;
            m_cycle_count_reg <= ex.cycle_count;
            m_next_pc_reg     <= pc_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_mem_addr    = m_mem_addr_reg;
    assign m_write_data  = m_write_data_reg;
    assign m_dest_index  = m_dest_index_reg;
    assign m_dest_value  = m_dest_value_reg;
    assign m_cycle_count = m_cycle_count_reg;
    assign m_next_pc     = m_next_pc_reg;

    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

    a_read_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && ex.kind == btx_pkg::KIND_READ |=> load_pending_reg)
        else $error("read request did not leave a pending load");

    a_pending_completes: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && action_reg && load_pending_reg
        |=> m_valid_reg && m_kind_reg == btx_pkg::KIND_REG && !load_pending_reg)
        else $error("pending load not completed by read data");

    a_bad_keeps_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (ex.kind == btx_pkg::KIND_BAD || ex.kind == btx_pkg::KIND_STRAY)
        |=> pc_reg == $past(pc_reg) && m_next_pc_reg == pc_reg)
        else $error("PC moved on an error result");

endmodule

[rtl/core/btx_regfile.sv]
module btx_regfile (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             we,
    input  logic [2:0]       code,
    input  logic [7:0]       wdata,
    output btx_pkg::regs_t   regs
);

    btx_pkg::regs_t regs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= '0;
        end else if (we) begin
            regs_reg[btx_pkg::slot_of(code)] <= wdata;
        end
    end

    assign regs = regs_reg;

endmodule

[rtl/core/btx_exec.sv]
module btx_exec (
    input  logic             action,
    input  logic [7:0]       opcode,
    input  logic [15:0]      operand_word,
    input  logic [7:0]       read_data,
    input  btx_pkg::regs_t   regs,
    input  logic             load_pending,
    input  logic [2:0]       pending_dest,
    input  logic [3:0]       pending_cycles,
    output btx_pkg::exec_t   ex
);

    logic [2:0]  src;
    logic [2:0]  dst;
    logic [7:0]  src_val;
    logic [7:0]  acc_val;
    logic [15:0] addr_hl;
    logic [15:0] addr_bc;
    logic [15:0] addr_de;

    assign src     = opcode[2:0];
    assign dst     = opcode[5:3];
    assign src_val = regs[btx_pkg::slot_of(src)];
    assign acc_val = regs[btx_pkg::slot_of(btx_pkg::REG_A)];
    assign addr_hl = {regs[btx_pkg::slot_of(btx_pkg::REG_H)],
                      regs[btx_pkg::slot_of(btx_pkg::REG_L)]};
    assign addr_bc = {regs[btx_pkg::slot_of(btx_pkg::REG_B)],
                      regs[btx_pkg::slot_of(btx_pkg::REG_C)]};
    assign addr_de = {regs[btx_pkg::slot_of(btx_pkg::REG_D)],
                      regs[btx_pkg::slot_of(btx_pkg::REG_E)]};

    always_comb begin
        ex = '0;
        ex.dest_index = btx_pkg::NO_REG;
        if (action) begin
            if (load_pending) begin
                ex.kind        = btx_pkg::KIND_REG;
                ex.dest_index  = pending_dest;
                ex.dest_value  = read_data;
                ex.cycle_count = pending_cycles;
                ex.reg_we      = 1'b1;
                ex.reg_code    = pending_dest;
                ex.reg_wdata   = read_data;
                ex.pend_clear  = 1'b1;
            end else begin
                ex.kind = btx_pkg::KIND_STRAY;
            end
        end else if (opcode inside {[btx_pkg::OP_MOV_LO:btx_pkg::OP_MOV_HI]}
                     && opcode != btx_pkg::OP_MOV_MM) begin
            ex.pc_inc     = 2'd1;
            ex.pend_clear = 1'b1;
            if (src == btx_pkg::NO_REG) begin
                ex.kind        = btx_pkg::KIND_READ;
                ex.mem_addr    = addr_hl;
                ex.cycle_count = btx_pkg::CYC_SHORT;
                ex.pend_set    = 1'b1;
                ex.pend_dest   = dst;
                ex.pend_cycles = btx_pkg::CYC_SHORT;
            end else if (dst == btx_pkg::NO_REG) begin
                ex.kind        = btx_pkg::KIND_WRITE;
                ex.mem_addr    = addr_hl;
                ex.write_data  = src_val;
                ex.cycle_count = btx_pkg::CYC_SHORT;
            end else begin
                ex.kind        = btx_pkg::KIND_REG;
                ex.dest_index  = dst;
                ex.dest_value  = src_val;
                ex.cycle_count = btx_pkg::CYC_MOV;
                ex.reg_we      = 1'b1;
                ex.reg_code    = dst;
                ex.reg_wdata   = src_val;
            end
        end else if ((opcode & btx_pkg::OP_MVI_MASK) == btx_pkg::OP_MVI_PAT) begin
            ex.pc_inc     = 2'd2;
            ex.pend_clear = 1'b1;
            if (dst == btx_pkg::NO_REG) begin
                ex.kind        = btx_pkg::KIND_WRITE;
                ex.mem_addr    = addr_hl;
                ex.write_data  = operand_word[7:0];
                ex.cycle_count = btx_pkg::CYC_MVI_MEM;
            end else begin
                ex.kind        = btx_pkg::KIND_REG;
                ex.dest_index  = dst;
                ex.dest_value  = operand_word[7:0];
                ex.cycle_count = btx_pkg::CYC_SHORT;
                ex.reg_we      = 1'b1;
                ex.reg_code    = dst;
                ex.reg_wdata   = operand_word[7:0];
            end
        end else if (opcode == btx_pkg::OP_STAX_B || opcode == btx_pkg::OP_STAX_D) begin
            ex.pc_inc      = 2'd1;
            ex.pend_clear  = 1'b1;
            ex.kind        = btx_pkg::KIND_WRITE;
            ex.mem_addr    = (opcode == btx_pkg::OP_STAX_B) ? addr_bc : addr_de;
            ex.write_data  = acc_val;
            ex.cycle_count = btx_pkg::CYC_SHORT;
        end else if (opcode == btx_pkg::OP_LDAX_B || opcode == btx_pkg::OP_LDAX_D) begin
            ex.pc_inc      = 2'd1;
            ex.pend_clear  = 1'b1;
            ex.kind        = btx_pkg::KIND_READ;
            ex.mem_addr    = (opcode == btx_pkg::OP_LDAX_B) ? addr_bc : addr_de;
            ex.cycle_count = btx_pkg::CYC_SHORT;
            ex.pend_set    = 1'b1;
            ex.pend_dest   = btx_pkg::REG_A;
            ex.pend_cycles = btx_pkg::CYC_SHORT;
        end else if (opcode == btx_pkg::OP_STA) begin
            ex.pc_inc      = 2'd3;
            ex.pend_clear  = 1'b1;
            ex.kind        = btx_pkg::KIND_WRITE;
            ex.mem_addr    = operand_word;
            ex.write_data  = acc_val;
            ex.cycle_count = btx_pkg::CYC_DIRECT;
        end else if (opcode == btx_pkg::OP_LDA) begin
            ex.pc_inc      = 2'd3;
            ex.pend_clear  = 1'b1;
            ex.kind        = btx_pkg::KIND_READ;
            ex.mem_addr    = operand_word;
            ex.cycle_count = btx_pkg::CYC_DIRECT;
            ex.pend_set    = 1'b1;
            ex.pend_dest   = btx_pkg::REG_A;
            ex.pend_cycles = btx_pkg::CYC_DIRECT;
        end else begin
            ex.kind = btx_pkg::KIND_BAD;
        end
    end

endmodule
